// ----- design/binary_max_heap_core_assert.svh -----
// Assertion macros shared by the heap core. Each checks an implication on the
// rising clock edge and is switched off while reset is high.
`ifndef BINARY_MAX_HEAP_CORE_ASSERT_SVH
`define BINARY_MAX_HEAP_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BMH_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication on the following edge.
`define BMH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BMH_ASSERT_NOW(lbl, ante, cons, msg)
`define BMH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- design/bmh_pkg.sv -----
package bmh_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = ADDR_W + 1;
   localparam int KEY_W  = 64;
   localparam int OCC_W  = 11;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [OCC_W-1:0]        occ_type;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_LAST,
      ST_UP_CHECK,
      ST_UP_CMP,
      ST_DN_CHECK,
      ST_DN_CMP,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_PUSH_BEGIN,
      OP_POP_BEGIN,
      OP_REJECT_FULL,
      OP_REJECT_EMPTY,
      OP_LOAD_LAST,
      OP_UP_READ,
      OP_UP_MOVE,
      OP_DN_READ,
      OP_DN_MOVE,
      OP_WRITE_KEY,
      OP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic full;
      logic empty;
      logic last_one;
      logic at_root;
      logic leaf;
      logic up_greater;
      logic dn_greater;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- design/bmh_req_if.sv -----
interface bmh_req_if import bmh_pkg::*; ();
   logic     valid;
   logic     ready;
   func_type func;
   key_type  key;

   modport source (output valid, output func, output key, input ready);
   modport sink   (input valid, input func, input key, output ready);
endinterface

// ----- design/bmh_rsp_if.sv -----
interface bmh_rsp_if import bmh_pkg::*; ();
   logic       valid;
   logic       ready;
   key_type    popped;
   key_type    top;
   occ_type    occupancy;
   status_type status;

   modport source (output valid, output popped, output top, output occupancy,
                   output status, input ready);
   modport sink   (input valid, input popped, input top, input occupancy,
                   input status, output ready);
endinterface

// ----- design/binary_max_heap_core.sv -----
// Channel  Dir  Payload                               Transfer
// req_chan in   func, key                             valid && ready
// rsp_chan out  popped, top, occupancy, status        valid && ready
//
// Transaction length is set by the sift: each level is one read of the heap memory
// and one compare with a write back. A push moves the new key up towards the root
// and a pop sinks the last key down from the root towards a leaf; rejects and a pop
// of the last key skip the sift. Reset clears the fill count, not the store.
// A held result stalls only the response stage of the next transaction, not its acceptance.

module binary_max_heap_core import bmh_pkg::*; (
   input logic      clock,
   input logic      reset,
   bmh_req_if.sink  req_chan,
   bmh_rsp_if.source rsp_chan
);

   // The controller steps through the sift one level at a time, while the
   // datapath holds the store, the hole position and the key being placed.
   // The sift moves a hole rather than swapping pairs of entries: the moving
   // key stays in a register and is written once, where it comes to rest.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          ctrl_ready;

   bmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   bmh_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .dp_status     (dp_status),
      .req_func      (req_chan.func),
      .req_key       (req_chan.key),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_popped    (rsp_chan.popped),
      .rsp_top       (rsp_chan.top),
      .rsp_occupancy (rsp_chan.occupancy),
      .rsp_status    (rsp_chan.status)
   );

   // The request transaction is taken only while the controller is idle.
   assign req_chan.ready = ctrl_ready;

endmodule

// ----- design/bmh_ctrl.sv -----
`include "binary_max_heap_core_assert.svh"

module bmh_ctrl import bmh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (dp_status.is_pop) begin
                  if (dp_status.empty) begin
                     state_in = ST_FINISH;
                  end else if (dp_status.last_one) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_POP_LAST;
                  end
               end else if (dp_status.full) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_UP_CHECK;
               end
            end
         end
         ST_POP_LAST: state_in = ST_DN_CHECK;
         ST_UP_CHECK: state_in = dp_status.at_root ? ST_FINISH : ST_UP_CMP;
         ST_UP_CMP:   state_in = dp_status.up_greater ? ST_UP_CHECK : ST_FINISH;
         ST_DN_CHECK: state_in = dp_status.leaf ? ST_FINISH : ST_DN_CMP;
         ST_DN_CMP:   state_in = dp_status.dn_greater ? ST_DN_CHECK : ST_FINISH;
         ST_FINISH:   state_in = dp_status.rsp_free ? ST_IDLE : ST_FINISH;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      dp_cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (dp_status.is_pop) begin
                  dp_cmd.op = dp_status.empty ? OP_REJECT_EMPTY : OP_POP_BEGIN;
               end else begin
                  dp_cmd.op = dp_status.full ? OP_REJECT_FULL : OP_PUSH_BEGIN;
               end
            end
         end
         ST_POP_LAST: dp_cmd.op = OP_LOAD_LAST;
         ST_UP_CHECK: dp_cmd.op = dp_status.at_root ? OP_WRITE_KEY : OP_UP_READ;
         ST_UP_CMP:   dp_cmd.op = dp_status.up_greater ? OP_UP_MOVE : OP_WRITE_KEY;
         ST_DN_CHECK: dp_cmd.op = dp_status.leaf ? OP_WRITE_KEY : OP_DN_READ;
         ST_DN_CMP:   dp_cmd.op = dp_status.dn_greater ? OP_DN_MOVE : OP_WRITE_KEY;
         ST_FINISH:   dp_cmd.op = dp_status.rsp_free ? OP_RESPOND : OP_NONE;
         default:     dp_cmd.op = OP_NONE;
      endcase
   end

   // A comparison is only ever made on data read in the cycle before.
   `BMH_ASSERT_NOW(a_up_cmp_after_read, state_ff == ST_UP_CMP,
      $past(state_ff) == ST_UP_CHECK, "sift-up compare without a parent read")
   `BMH_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
      "second transaction accepted while one is in progress")
   `BMH_ASSERT_NEXT(a_finish_holds, state_ff == ST_FINISH && !dp_status.rsp_free,
      state_ff == ST_FINISH, "response stage left while the result register is held")

endmodule

// ----- design/bmh_dpath.sv -----
`include "binary_max_heap_core_assert.svh"

module bmh_dpath import bmh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   input  func_type      req_func,
   input  key_type       req_key,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output key_type       rsp_popped,
   output key_type       rsp_top,
   output occ_type       rsp_occupancy,
   output status_type    rsp_status
);

   key_type    heap_mem_ff [DEPTH];
   key_type    rd_a_ff;
   key_type    rd_b_ff;

   count_type  count_ff,      count_in;
   addr_type   pos_ff,        pos_in;
   key_type    cur_key_ff,    cur_key_in;
   key_type    root_ff,       root_in;
   key_type    popped_ff,     popped_in;
   status_type status_ff,     status_in;
   logic       rsp_valid_ff,  rsp_valid_in;
   key_type    rsp_popped_ff, rsp_popped_in;
   key_type    rsp_top_ff,    rsp_top_in;
   occ_type    rsp_occ_ff,    rsp_occ_in;
   status_type rsp_status_ff, rsp_status_in;

   logic       mem_we;
   addr_type   mem_waddr;
   key_type    mem_wdata;
   addr_type   raddr_a;
   addr_type   raddr_b;

   idx_type    count_ext;
   idx_type    left_idx;
   idx_type    right_idx;
   addr_type   pos_dec;
   addr_type   parent_pos;
   count_type  count_dec;
   logic       right_ok;
   logic       pick_right;
   key_type    pick_key;
   addr_type   pick_pos;
   logic       rsp_free;

   // Tree navigation around the current hole position.
   always_comb begin
      count_ext  = IDX_W'(count_ff);
      count_dec  = count_ff - count_type'(1);
      left_idx   = {pos_ff, 1'b1};
      right_idx  = left_idx + idx_type'(1);
      pos_dec    = pos_ff - addr_type'(1);
      parent_pos = pos_dec >> 1;
      right_ok   = right_idx < count_ext;
      pick_right = right_ok && (rd_b_ff > rd_a_ff);
      pick_key   = pick_right ? rd_b_ff : rd_a_ff;
      pick_pos   = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
      rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      dp_status.is_pop     = req_func == FUNC_POP;
      dp_status.full       = count_ff == count_type'(DEPTH);
      dp_status.empty      = count_ff == '0;
      dp_status.last_one   = count_ff == count_type'(1);
      dp_status.at_root    = pos_ff == '0;
      dp_status.leaf       = left_idx >= count_ext;
      dp_status.up_greater = cur_key_ff > rd_a_ff;
      dp_status.dn_greater = pick_key > cur_key_ff;
      dp_status.rsp_free   = rsp_free;
   end

   // Memory port control.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = cur_key_ff;
      raddr_a   = '0;
      raddr_b   = '0;
      case (dp_cmd.op)
         OP_POP_BEGIN: raddr_a = addr_type'(count_dec);
         OP_UP_READ:   raddr_a = parent_pos;
         OP_DN_READ: begin
            raddr_a = left_idx[ADDR_W-1:0];
            raddr_b = right_idx[ADDR_W-1:0];
         end
         OP_UP_MOVE: begin
            mem_we    = 1'b1;
            mem_wdata = rd_a_ff;
         end
         OP_DN_MOVE: begin
            mem_we    = 1'b1;
            mem_wdata = pick_key;
         end
         OP_WRITE_KEY: mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= heap_mem_ff[raddr_a];
      rd_b_ff <= heap_mem_ff[raddr_b];
   end

   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      cur_key_in    = cur_key_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      root_in       = (mem_we && (mem_waddr == '0)) ? mem_wdata : root_ff;
      case (dp_cmd.op)
         OP_PUSH_BEGIN: begin
            cur_key_in = req_key;
            pos_in     = addr_type'(count_ff);
            count_in   = count_ff + count_type'(1);
            popped_in  = '0;
            status_in  = STATUS_OK;
         end
         OP_POP_BEGIN: begin
            pos_in    = '0;
            count_in  = count_dec;
            popped_in = root_ff;
            status_in = STATUS_OK;
         end
         OP_REJECT_FULL: begin
            popped_in = '0;
            status_in = STATUS_FULL;
         end
         OP_REJECT_EMPTY: begin
            popped_in = '0;
            status_in = STATUS_EMPTY;
         end
         OP_LOAD_LAST: cur_key_in = rd_a_ff;
         OP_UP_MOVE:   pos_in = parent_pos;
         OP_DN_MOVE:   pos_in = pick_pos;
         OP_RESPOND: begin
            rsp_valid_in  = 1'b1;
            rsp_popped_in = popped_ff;
            rsp_top_in    = (count_ff != '0) ? root_ff : '0;
            rsp_occ_in    = OCC_W'(count_ff);
            rsp_status_in = status_ff;
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cur_key_ff    <= cur_key_in;
      root_ff       <= root_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_popped    = rsp_popped_ff;
   assign rsp_top       = rsp_top_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_status    = rsp_status_ff;

   `BMH_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= count_type'(DEPTH),
      "fill count above the store depth")
   `BMH_ASSERT_NOW(a_write_in_heap, mem_we, IDX_W'(mem_waddr) < count_ext,
      "store written outside the occupied entries")
   `BMH_ASSERT_NOW(a_respond_free, dp_cmd.op == OP_RESPOND, rsp_free,
      "result register overwritten while still held")

endmodule
